/* rtl/camera_basis_from_yaw_pitch_assert.svh */
// Assertion macros shared by the checker files of this block.
`ifndef CAMERA_BASIS_FROM_YAW_PITCH_ASSERT_SVH
`define CAMERA_BASIS_FROM_YAW_PITCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBYP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBYP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cbyp_pkg.sv */
package cbyp_pkg;

	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int ZW = 34;
	localparam int XW = 34;
	localparam int RW = 34;

	localparam logic signed [ZW-1:0] Q30_PI = 34'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [XW-1:0] Q30_GAIN = 34'sd652032874;

	localparam logic [29:0] ATAN_Q30 [31] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
		30'h00000001
	};

	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
	} ang_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic signed [15:0] fwd_x;
		logic signed [15:0] fwd_y;
		logic signed [15:0] fwd_z;
		logic degenerate;
	} basis_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic neg;
	} rot_t;

	typedef struct packed {
		logic valid;
		rot_t yaw;
		rot_t pitch;
	} rot_pair_t;

endpackage

/* rtl/camera_basis_from_yaw_pitch.sv */
// Camera basis from yaw and pitch.
// Input channel ang_valid / ang_stall / ang carries a yaw and a pitch angle in
// radians with 13 fraction bits. Output channel basis_valid / basis_stall /
// basis carries the right, up and forward axes with OUT_FRAC_BITS fraction
// bits, plus a degenerate flag that is set when cos pitch is exactly zero.
// A transaction completes on a rising edge with valid high and stall low.
// Two rotation CORDICs, one per angle, run side by side: a register for the
// range-reduced angle, then one stage per iteration. They are followed by a
// multiply stage, a sign stage, a rounding stage and the output register.
// One transaction can be taken in every cycle while ang_stall is low, so
// throughput is one result per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and a skid
// register catches the item leaving the pipeline; the whole pipeline then
// freezes and ang_stall stays high until the held result is taken.
// Reset clears all valid bits; the block holds no other state and needs no
// clearing pass.
module camera_basis_from_yaw_pitch #(
	parameter int OUT_FRAC_BITS = cbyp_pkg::OUT_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = cbyp_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic ang_valid,
	output logic ang_stall,
	input cbyp_pkg::ang_t ang,
	output logic basis_valid,
	input logic basis_stall,
	output cbyp_pkg::basis_t basis
);
	import cbyp_pkg::*;

	logic ce;
	logic take;
	logic res_valid;
	basis_t res;
	rot_pair_t rot;

	logic out_v_q, skid_v_q;
	basis_t out_q, skid_q;

	assign ce = !skid_v_q;
	assign ang_stall = skid_v_q;
	assign take = out_v_q && !basis_stall;

	cbyp_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.ce(ce),
		.in_valid(ang_valid),
		.ang(ang),
		.rot(rot)
	);

	cbyp_combine #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_combine (
		.clk(clk),
		.arst_n(arst_n),
		.ce(ce),
		.rot(rot),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= res_valid;
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || take) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign basis_valid = out_v_q;
	assign basis = out_q;

endmodule

/* rtl/cbyp_cordic.sv */
module cbyp_cordic #(
	parameter int STAGES = cbyp_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic ce,
	input logic in_valid,
	input cbyp_pkg::ang_t ang,
	output cbyp_pkg::rot_pair_t rot
);
	import cbyp_pkg::*;

	localparam int LANES = 2;

	logic signed [15:0] ang_w [LANES];
	logic signed [ZW-1:0] zw_w [LANES];
	logic signed [ZW-1:0] zr_w [LANES];
	logic negr_w [LANES];

	logic signed [XW-1:0] xin_w [LANES][STAGES];
	logic signed [XW-1:0] yin_w [LANES][STAGES];
	logic signed [XW-1:0] xn_w [LANES][STAGES];
	logic signed [XW-1:0] yn_w [LANES][STAGES];
	logic signed [ZW-1:0] zn_w [LANES][STAGES];

	logic signed [XW-1:0] x_s [LANES][STAGES];
	logic signed [XW-1:0] y_s [LANES][STAGES];
	logic signed [ZW-1:0] z_s [LANES][STAGES];
	logic neg_s [LANES][STAGES+1];
	logic [STAGES:0] v_s;

	assign ang_w[0] = ang.yaw;
	assign ang_w[1] = ang.pitch;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			zw_w[l] = $signed({ang_w[l][15], ang_w[l], 17'd0});
			if (zw_w[l] > Q30_HALF_PI) begin
				zr_w[l] = zw_w[l] - Q30_PI;
				negr_w[l] = 1'b1;
			end else if (zw_w[l] < -Q30_HALF_PI) begin
				zr_w[l] = zw_w[l] + Q30_PI;
				negr_w[l] = 1'b1;
			end else begin
				zr_w[l] = zw_w[l];
				negr_w[l] = 1'b0;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			xin_w[l][0] = Q30_GAIN;
			yin_w[l][0] = '0;
			for (int i = 1; i < STAGES; i++) begin
				xin_w[l][i] = x_s[l][i-1];
				yin_w[l][i] = y_s[l][i-1];
			end
			for (int i = 0; i < STAGES; i++) begin
				if (z_s[l][i] >= 0) begin
					xn_w[l][i] = xin_w[l][i] - (yin_w[l][i] >>> i);
					yn_w[l][i] = yin_w[l][i] + (xin_w[l][i] >>> i);
					zn_w[l][i] = z_s[l][i] - ZW'(ATAN_Q30[i]);
				end else begin
					xn_w[l][i] = xin_w[l][i] + (yin_w[l][i] >>> i);
					yn_w[l][i] = yin_w[l][i] - (xin_w[l][i] >>> i);
					zn_w[l][i] = z_s[l][i] + ZW'(ATAN_Q30[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANES; l++) begin
				z_s[l][0] <= zr_w[l];
				neg_s[l][0] <= negr_w[l];
				for (int i = 0; i < STAGES; i++) begin
					x_s[l][i] <= xn_w[l][i];
					y_s[l][i] <= yn_w[l][i];
					neg_s[l][i+1] <= neg_s[l][i];
				end
				for (int i = 0; i < STAGES - 1; i++) begin
					z_s[l][i+1] <= zn_w[l][i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (ce) begin
			v_s <= {v_s[STAGES-1:0], in_valid};
		end
	end

	assign rot.valid = v_s[STAGES];
	assign rot.yaw.x = x_s[0][STAGES-1];
	assign rot.yaw.y = y_s[0][STAGES-1];
	assign rot.yaw.neg = neg_s[0][STAGES];
	assign rot.pitch.x = x_s[1][STAGES-1];
	assign rot.pitch.y = y_s[1][STAGES-1];
	assign rot.pitch.neg = neg_s[1][STAGES];

endmodule

/* rtl/cbyp_combine.sv */
module cbyp_combine #(
	parameter int OUT_FRAC_BITS = cbyp_pkg::OUT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic ce,
	input cbyp_pkg::rot_pair_t rot,
	output logic res_valid,
	output cbyp_pkg::basis_t res
);
	import cbyp_pkg::*;

	localparam int NT = 4;
	localparam int PW = 64;
	localparam int SH_S = 30 - OUT_FRAC_BITS;
	localparam int SH_P = 60 - OUT_FRAC_BITS;
	localparam logic signed [XW-1:0] HALF_S = XW'((64'd1 << SH_S) >> 1);
	localparam logic signed [PW-1:0] HALF_P = PW'((64'd1 << SH_P) >> 1);
	localparam logic signed [RW-1:0] LIM = RW'(64'd1 << OUT_FRAC_BITS);

	function automatic logic [15:0] sat16(input logic signed [RW-1:0] r);
		logic signed [RW-1:0] t;
		if (r > LIM) begin
			t = LIM;
		end else if (r < -LIM) begin
			t = -LIM;
		end else begin
			t = r;
		end
		return t[15:0];
	endfunction

	logic signed [31:0] yx_w, yy_w, px_w, py_w;
	logic cpn_w, ny_w, np_w;

	logic signed [PW-1:0] prod_s1 [NT];
	logic signed [XW-1:0] sing_s1 [NT];
	logic [NT-1:0] pflip_s1, sflip_s1;
	logic degen_s1, v_s1;

	logic signed [PW-1:0] pneg_s2 [NT];
	logic signed [XW-1:0] sneg_s2 [NT];
	logic degen_s2, v_s2;

	logic signed [PW-1:0] psum_w [NT];
	logic signed [XW-1:0] ssum_w [NT];
	logic signed [RW-1:0] prnd_s3 [NT];
	logic signed [RW-1:0] srnd_s3 [NT];
	logic degen_s3, v_s3;

	assign yx_w = rot.yaw.x[31:0];
	assign yy_w = rot.yaw.y[31:0];
	assign px_w = rot.pitch.x[31:0];
	assign py_w = rot.pitch.y[31:0];
	assign ny_w = rot.yaw.neg;
	assign np_w = rot.pitch.neg;

	// The sign of cos pitch is the raw CORDIC sign flipped by the range reduction.
	assign cpn_w = (rot.pitch.x != '0) && (rot.pitch.x[XW-1] ^ np_w);

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1[0] <= py_w * yx_w;
			prod_s1[1] <= py_w * yy_w;
			prod_s1[2] <= yx_w * px_w;
			prod_s1[3] <= yy_w * px_w;
			sing_s1[0] <= rot.yaw.y;
			sing_s1[1] <= rot.yaw.x;
			sing_s1[2] <= rot.pitch.x;
			sing_s1[3] <= rot.pitch.y;
			sflip_s1 <= {np_w, cpn_w ^ np_w, ~cpn_w ^ ny_w, cpn_w ^ ny_w};
			pflip_s1 <= {ny_w ^ np_w, ny_w ^ np_w, ~cpn_w ^ np_w ^ ny_w,
				~cpn_w ^ np_w ^ ny_w};
			degen_s1 <= (rot.pitch.x == '0);

			for (int k = 0; k < NT; k++) begin
				pneg_s2[k] <= pflip_s1[k] ? -prod_s1[k] : prod_s1[k];
				sneg_s2[k] <= sflip_s1[k] ? -sing_s1[k] : sing_s1[k];
			end
			degen_s2 <= degen_s1;

			for (int k = 0; k < NT; k++) begin
				prnd_s3[k] <= psum_w[k][RW-1:0];
				srnd_s3[k] <= ssum_w[k][RW-1:0];
			end
			degen_s3 <= degen_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < NT; k++) begin
			psum_w[k] = (pneg_s2[k] + HALF_P) >>> SH_P;
			ssum_w[k] = (sneg_s2[k] + HALF_S) >>> SH_S;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= rot.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign res_valid = v_s3;
	assign res.right_x = sat16(srnd_s3[0]);
	assign res.right_y = '0;
	assign res.right_z = sat16(srnd_s3[1]);
	assign res.up_x = sat16(prnd_s3[0]);
	assign res.up_y = sat16(srnd_s3[2]);
	assign res.up_z = sat16(prnd_s3[1]);
	assign res.fwd_x = sat16(prnd_s3[2]);
	assign res.fwd_y = sat16(srnd_s3[3]);
	assign res.fwd_z = sat16(prnd_s3[3]);
	assign res.degenerate = degen_s3;

endmodule

/* rtl/cbyp_checker.sv */
`include "camera_basis_from_yaw_pitch_assert.svh"

module cbyp_checker (
	input logic clk,
	input logic arst_n,
	input logic basis_valid,
	input logic basis_stall,
	input cbyp_pkg::basis_t basis
);
	import cbyp_pkg::*;

	`CBYP_ASSERT_NEXT(a_valid_held, clk, arst_n, basis_valid && basis_stall, basis_valid, "stalled result dropped")
	`CBYP_ASSERT_NEXT(a_data_held, clk, arst_n, basis_valid && basis_stall, $stable(basis), "stalled result changed")
	`CBYP_ASSERT_NOW(a_right_y_zero, clk, arst_n, basis_valid, basis.right_y == '0, "right_y is not zero")
	`CBYP_ASSERT_NOW(a_degenerate, clk, arst_n, basis_valid && basis.degenerate, (basis.up_y == '0) && (basis.fwd_x == '0) && (basis.fwd_z == '0), "degenerate result has nonzero cos pitch terms")

endmodule

bind camera_basis_from_yaw_pitch cbyp_checker u_cbyp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.basis_valid(basis_valid),
	.basis_stall(basis_stall),
	.basis(basis)
);

/* bench/camera_basis_from_yaw_pitch_tb.sv */
`timescale 1ns / 1ps

module camera_basis_from_yaw_pitch_tb;
	import cbyp_pkg::*;

	localparam int OUT_FRAC = 14;
	localparam int STAGES = 16;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

	class basis_scoreboard;
		basis_t expected_basis[$];
		int mismatches;

		function longint arctan_q30(int stage);
			case (stage)
				0: return 64'h3243F6A8;
				1: return 64'h1DAC6705;
				2: return 64'h0FADBAFC;
				3: return 64'h07F56EA6;
				4: return 64'h03FEAB76;
				5: return 64'h01FFD55B;
				6: return 64'h00FFFAAA;
				7: return 64'h007FFF55;
				8: return 64'h003FFFEA;
				9: return 64'h001FFFFD;
				10: return 64'h000FFFFF;
				11: return 64'h0007FFFF;
				12: return 64'h0003FFFF;
				13: return 64'h0001FFFF;
				14: return 64'h0000FFFF;
				15: return 64'h00007FFF;
				default: return 64'h0;
			endcase
		endfunction

		function void cordic_sin_cos(input logic signed [15:0] ang, output longint c,
				output longint s);
			longint z;
			longint x;
			longint y;
			longint dx;
			longint dy;
			bit neg;
			z = longint'(ang) * 131072;
			x = GAIN_Q30;
			y = 0;
			neg = 1'b0;
			if (z > HALF_PI_Q30) begin
				z -= PI_Q30;
				neg = 1'b1;
			end else if (z < -HALF_PI_Q30) begin
				z += PI_Q30;
				neg = 1'b1;
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= arctan_q30(i);
				end else begin
					x += dx;
					y -= dy;
					z += arctan_q30(i);
				end
			end
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function logic [15:0] round_sat(longint v, int sh);
			longint r;
			longint lim;
			lim = longint'(1) <<< OUT_FRAC;
			r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
			if (r > lim)
				r = lim;
			if (r < -lim)
				r = -lim;
			return r[15:0];
		endfunction

		function void note_angles(ang_t a);
			longint cy;
			longint sy;
			longint cp;
			longint sp;
			longint sg;
			basis_t e;
			cordic_sin_cos(a.yaw, cy, sy);
			cordic_sin_cos(a.pitch, cp, sp);
			sg = (cp < 0) ? -1 : 1;
			e.right_x = round_sat(sg * sy, 30 - OUT_FRAC);
			e.right_y = '0;
			e.right_z = round_sat(-sg * cy, 30 - OUT_FRAC);
			e.up_x = round_sat(-sg * (sp * cy), 60 - OUT_FRAC);
			e.up_y = round_sat(sg * cp, 30 - OUT_FRAC);
			e.up_z = round_sat(-sg * (sp * sy), 60 - OUT_FRAC);
			e.fwd_x = round_sat(cy * cp, 60 - OUT_FRAC);
			e.fwd_y = round_sat(sp, 30 - OUT_FRAC);
			e.fwd_z = round_sat(sy * cp, 60 - OUT_FRAC);
			e.degenerate = (cp == 0);
			expected_basis.push_back(e);
		endfunction

		function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
			if (got_v !== exp_v) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on %s: expected %0d, actual %0d", name,
						$signed(exp_v), $signed(got_v));
			end
		endfunction

		function void check_basis(basis_t got);
			basis_t e;
			if (expected_basis.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected basis transaction: %h", got);
				return;
			end
			e = expected_basis.pop_front();
			compare_field("right_x", e.right_x, got.right_x);
			compare_field("right_y", e.right_y, got.right_y);
			compare_field("right_z", e.right_z, got.right_z);
			compare_field("up_x", e.up_x, got.up_x);
			compare_field("up_y", e.up_y, got.up_y);
			compare_field("up_z", e.up_z, got.up_z);
			compare_field("fwd_x", e.fwd_x, got.fwd_x);
			compare_field("fwd_y", e.fwd_y, got.fwd_y);
			compare_field("fwd_z", e.fwd_z, got.fwd_z);
			compare_field("degenerate", {15'b0, e.degenerate}, {15'b0, got.degenerate});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ang_valid = 1'b0;
	logic ang_stall;
	ang_t ang = '0;
	logic basis_valid;
	logic basis_stall = 1'b0;
	basis_t basis;

	basis_scoreboard sb;
	int cycle_count = 0;
	stall_mode_e stall_mode = STALL_NONE;
	int stall_left = 0;

	camera_basis_from_yaw_pitch u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.ang_valid(ang_valid),
		.ang_stall(ang_stall),
		.ang(ang),
		.basis_valid(basis_valid),
		.basis_stall(basis_stall),
		.basis(basis)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && basis_valid === 1'b1 && !basis_stall)
			sb.check_basis(basis);
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 80);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: basis_stall <= 1'b0;
			STALL_LIGHT: basis_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: basis_stall <= ($urandom_range(0, 3) != 0);
			default: basis_stall <= ~basis_stall;
		endcase
	end

	task automatic send_angles(input logic signed [15:0] yaw, input logic signed [15:0] pitch);
		ang_t a;
		a.yaw = yaw;
		a.pitch = pitch;
		ang <= a;
		ang_valid <= 1'b1;
		do
			@(posedge clk);
		while (ang_stall);
		sb.note_angles(a);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		ang_valid <= 1'b0;
		ang <= ang_t'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic signed [15:0] near_angle(logic signed [15:0] center);
		logic signed [15:0] v;
		v = center + 16'($urandom_range(0, 40)) - 16'sd20;
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			return 16'($urandom);
		else if (kind < 6)
			return near_angle(HALF_PI_Q13);
		else if (kind < 8)
			return near_angle(PI_Q13);
		else if (kind == 8)
			return 16'($urandom_range(0, 64)) - 16'sd32;
		else
			return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3)) :
				16'sh8000 + 16'($urandom_range(0, 3));
	endfunction

	initial begin
		int sent;
		int burst;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_angles(16'sd0, 16'sd0);
		send_angles(16'sh7FFF, 16'sh7FFF);
		send_angles(-16'sh8000, -16'sh8000);
		send_angles(16'sh7FFF, -16'sh8000);
		send_angles(-16'sh8000, 16'sh7FFF);
		send_angles(16'sd0, HALF_PI_Q13);
		send_angles(16'sd0, -HALF_PI_Q13);
		send_angles(16'sd100, HALF_PI_Q13 - 16'sd1);
		send_angles(-16'sd100, -HALF_PI_Q13 + 16'sd1);
		send_angles(16'sd4000, HALF_PI_Q13 + 16'sd1);
		send_angles(HALF_PI_Q13, 16'sd0);
		send_angles(-HALF_PI_Q13, 16'sd0);
		send_angles(PI_Q13, 16'sd2000);
		send_angles(-PI_Q13, -16'sd2000);
		send_angles(16'sd3000, PI_Q13);
		send_angles(-16'sd3000, -PI_Q13);
		send_angles(16'sd20000, 16'sd18000);
		send_angles(-16'sd20000, -16'sd18000);
		send_angles(16'sd1, -16'sd1);
		send_angles(-16'sd1, 16'sd1);
		send_angles(16'sh5555, 16'shAAAA);
		send_angles(16'shAAAA, 16'sh5555);
		pause_sender(3);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_angles(pick_angle(), pick_angle());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 6));
		end
		pause_sender(1);

		while (sb.expected_basis.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_basis.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/cbyp_pkg.sv
rtl/cbyp_cordic.sv
rtl/cbyp_combine.sv
rtl/camera_basis_from_yaw_pitch.sv
rtl/cbyp_checker.sv
bench/camera_basis_from_yaw_pitch_tb.sv
